// ----- hdl/eprs_pkg.sv -----
package eprs_pkg;

   localparam int DIST_W = 20;
   localparam int TIMEOUT_W = 20;
   localparam int DIV_W = 8;
   localparam logic [DIST_W-1:0] DIST_MAX = 20'hFFFFF;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_ABORT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_ATTACHED      = 3'd0,
      REG_ECHO_LEVEL    = 3'd1,
      REG_TRIG_LEVEL    = 3'd2,
      REG_TRIG_WIDTH    = 3'd3,
      REG_START_TIMEOUT = 3'd4,
      REG_MAX_PULSE     = 3'd5,
      REG_US_PER_CM     = 3'd6
   } reg_idx_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_TRIG = 5'b00010,
      PH_WAIT = 5'b00100,
      PH_MEAS = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      CT_READY = 2'b01,
      CT_DIV   = 2'b10
   } ctl_type;

   localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_CODE_WAIT = 2'd1;
   localparam logic [1:0] PHASE_CODE_MEAS = 2'd2;
   localparam logic [1:0] PHASE_CODE_DONE = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- hdl/echo_pulse_ranging_sequencer_core.sv -----
// one result beat per input beat, held in an output register until taken
// the result of a beat is registered; a tick that ends a pulse measurement waits instead
//   for the bit-serial divider, which produces one quotient bit per cycle
// throughput: one beat per cycle while results are taken, except behind a finishing measurement
// reset: synchronous, active high; configuration registers take their defaults, phase idle
module echo_pulse_ranging_sequencer_core #(
   parameter int TIME_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // echo_level
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // trig_level, phase, busy_res, distance_cm, distance_valid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import eprs_pkg::*;

   localparam int CW = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

   logic                 attached_ff, echo_lvl_ff, trig_lvl_ff;
   logic [7:0]           trig_width_ff;
   logic [TIMEOUT_W-1:0] start_timeout_ff, max_pulse_ff;
   logic [DIV_W-1:0]     us_per_cm_ff;

   phase_type            phase_ff, phase_in;
   logic [7:0]           tc_ff, tc_in, tc_inc;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in, el_bump;
   logic [DIST_W-1:0]    distance_ff;
   ctl_type              ctl_ff, ctl_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_accept, csr_write, echo_on, busy_now, div_start;
   op_type               op;
   reg_idx_type          csr_idx;
   div_stat_type         div_stat;
   logic [DIST_W-1:0]    quotient;
   logic [DIV_W-1:0]     div_val;
   logic [1:0]           phase_code;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         attached_ff      <= 1'b0;
         echo_lvl_ff      <= 1'b1;
         trig_lvl_ff      <= 1'b1;
         trig_width_ff    <= 8'd10;
         start_timeout_ff <= TIMEOUT_W'(20000);
         max_pulse_ff     <= TIMEOUT_W'(30000);
         us_per_cm_ff     <= DIV_W'(58);
      end else if (csr_write) begin
         case (csr_idx)
            REG_ATTACHED:      attached_ff      <= csr_pwdata[0];
            REG_ECHO_LEVEL:    echo_lvl_ff      <= csr_pwdata[0];
            REG_TRIG_LEVEL:    trig_lvl_ff      <= csr_pwdata[0];
            REG_TRIG_WIDTH:    trig_width_ff    <= csr_pwdata[7:0];
            REG_START_TIMEOUT: start_timeout_ff <= csr_pwdata[TIMEOUT_W-1:0];
            REG_MAX_PULSE:     max_pulse_ff     <= csr_pwdata[TIMEOUT_W-1:0];
            REG_US_PER_CM:     us_per_cm_ff     <= csr_pwdata[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ATTACHED:      csr_prdata = {31'd0, attached_ff};
         REG_ECHO_LEVEL:    csr_prdata = {31'd0, echo_lvl_ff};
         REG_TRIG_LEVEL:    csr_prdata = {31'd0, trig_lvl_ff};
         REG_TRIG_WIDTH:    csr_prdata = 32'(trig_width_ff);
         REG_START_TIMEOUT: csr_prdata = 32'(start_timeout_ff);
         REG_MAX_PULSE:     csr_prdata = 32'(max_pulse_ff);
         REG_US_PER_CM:     csr_prdata = 32'(us_per_cm_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign op         = op_type'(req_tuser);
   assign echo_on    = req_tdata[0] == echo_lvl_ff;
   assign req_tready = (ctl_ff == CT_READY) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign busy_now   = (phase_ff == PH_TRIG) || (phase_ff == PH_WAIT) || (phase_ff == PH_MEAS);
   assign tc_inc     = (tc_ff != 8'hFF) ? tc_ff + 8'd1 : tc_ff;
   assign el_bump    = (elapsed_ff != '1) ? elapsed_ff + TIME_BITS'(1) : elapsed_ff;
   assign div_val    = (us_per_cm_ff == '0) ? DIV_W'(1) : us_per_cm_ff;

   always_comb begin
      phase_in   = phase_ff;
      tc_in      = tc_ff;
      elapsed_in = elapsed_ff;
      div_start  = 1'b0;
      if (req_accept) begin
         case (op)
            OP_START: begin
               if (!busy_now) begin
                  if (!attached_ff || echo_on) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_TRIG;
                     tc_in    = '0;
                  end
               end
            end
            OP_ABORT: phase_in = PH_IDLE;
            OP_TICK: begin
               if (!attached_ff) begin
                  phase_in = PH_IDLE;
               end else if (phase_ff == PH_TRIG) begin
                  tc_in = tc_inc;
                  if (tc_inc >= trig_width_ff) begin
                     // trigger over, poll at once with zero elapsed
                     elapsed_in = '0;
                     phase_in   = echo_on ? PH_MEAS : PH_WAIT;
                  end
               end else if (phase_ff == PH_WAIT) begin
                  elapsed_in = el_bump;
                  if (CW'(el_bump) > CW'(start_timeout_ff) && !echo_on) begin
                     phase_in = PH_IDLE;
                  end else if (echo_on) begin
                     phase_in   = PH_MEAS;
                     elapsed_in = '0;
                  end
               end else if (phase_ff == PH_MEAS) begin
                  elapsed_in = el_bump;
                  if (CW'(el_bump) > CW'(max_pulse_ff) && echo_on) begin
                     phase_in = PH_IDLE;
                  end else if (!echo_on) begin
                     phase_in  = PH_DONE;
                     div_start = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      ctl_in       = ctl_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = !div_start;
         if (div_start) begin
            ctl_in = CT_DIV;
         end
      end else if (div_stat.done) begin
         rsp_valid_in = 1'b1;
         ctl_in       = CT_READY;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      tc_ff      <= tc_in;
      elapsed_ff <= elapsed_in;
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ctl_ff       <= CT_READY;
         rsp_valid_ff <= 1'b0;
         distance_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         if (div_stat.done) begin
            distance_ff <= quotient;
         end
      end
   end

   eprs_div #(
      .TIME_BITS (TIME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start_in (div_start),
      .dividend (el_bump),
      .divisor  (div_val),
      .status   (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      case (phase_ff)
         PH_TRIG, PH_WAIT: phase_code = PHASE_CODE_WAIT;
         PH_MEAS:          phase_code = PHASE_CODE_MEAS;
         PH_DONE:          phase_code = PHASE_CODE_DONE;
         default:          phase_code = PHASE_CODE_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        phase_ff == PH_DONE,
                        (phase_ff == PH_DONE) ? distance_ff : {DIST_W{1'b0}},
                        busy_now,
                        phase_code,
                        (phase_ff == PH_TRIG) ? trig_lvl_ff : ~trig_lvl_ff};

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> ctl_ff == CT_DIV)
      else $error("divider finished outside divide state");

   a_no_rsp_in_div: assert property (@(posedge clock) disable iff (reset)
      ctl_ff == CT_DIV |-> !rsp_valid_ff)
      else $error("result shown during divide");

   a_start_div: assert property (@(posedge clock) disable iff (reset)
      div_start |=> ctl_ff == CT_DIV && div_stat.busy && phase_ff == PH_DONE)
      else $error("divide not started on finished measurement");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |=> rsp_valid_ff && ctl_ff == CT_READY)
      else $error("quotient not presented");

endmodule

// ----- hdl/eprs_div.sv -----
module eprs_div #(
   parameter int TIME_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start_in,
   input  logic [TIME_BITS-1:0]              dividend,
   input  logic [eprs_pkg::DIV_W-1:0]        divisor,
   output eprs_pkg::div_stat_type            status,
   output logic [eprs_pkg::DIST_W-1:0]       quotient
);
   import eprs_pkg::*;

   localparam int CNT_W = $clog2(TIME_BITS + 1);
   localparam int QW = (TIME_BITS > DIST_W) ? TIME_BITS : DIST_W;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [TIME_BITS-1:0] work_ff, work_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       trial;
   logic                 fits;
   logic [QW-1:0]        work_ext;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, work_ff[TIME_BITS-1]};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      work_in = work_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start_in) begin
         rem_in  = '0;
         dvs_in  = divisor;
         work_in = dividend;
         cnt_in  = CNT_W'(TIME_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         work_in = {work_ff[TIME_BITS-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      work_ff <= work_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign work_ext = QW'(work_ff);
   assign quotient = (work_ext > QW'(DIST_MAX)) ? DIST_MAX : work_ext[DIST_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
